[rtl/plsu_pkg.sv]
// shared types, codes and sizes for the positional list store
package plsu_pkg;

    // default number of cells in the chain
    localparam int CAPACITY_DEF = 16;

    // fixed field widths
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int CMD_W   = 2;

    // operation codes on the input item
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;

    // status codes on the result item
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    // commands broadcast to every cell
    localparam logic [CMD_W-1:0] CMD_HOLD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ROT  = 2'd3;

    // input item
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         length;
        logic                     last;
    } out_item_t;

    // control broadcast from the sequencer to the cells
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] cnt;
    } cell_ctl_t;

endpackage

[rtl/positional_list_store_unit.sv]
// top level of the positional list store: sequencer and chain of cells
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in a row of
// cells. An item is taken on a rising edge with start high and busy low.
// request.func selects insert at position, delete at position or dump.
// Every result appears on result for exactly one cycle with done high; the
// receiver always takes it, there is no stall path.
// Insert and delete shift the cells from the given position on in the accept
// cycle; their single result is registered and shows in the cycle after, and
// busy stays low, so such items may follow each other in every cycle.
// A dump of n values raises busy while the chain rotates by one cell a
// cycle; the head cell gives one registered result per cycle, the final one
// flagged by last, and no new item is taken until the dump is through.
// An empty dump, a bad position, a full store and the unused func code give
// one result in the cycle after acceptance and leave the list unchanged.
// Reset clears the count and the sequencer; cell contents stay undefined
// and are never read before being written.
module positional_list_store_unit #(
    parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plsu_pkg::in_item_t  request,
    output logic                done,
    output plsu_pkg::out_item_t result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                done_reg, done_next;
    plsu_pkg::out_item_t result_reg, result_next;
    plsu_pkg::cell_ctl_t ctl;

    logic signed [plsu_pkg::DATA_W-1:0] q [CAPACITY];

    logic                         accept;
    logic [plsu_pkg::POS_W:0]     pos_x;
    logic [plsu_pkg::POS_W:0]     cnt_x;
    logic [plsu_pkg::POS_W-1:0]   cnt7;
    logic                         ins_bad;
    logic                         del_bad;
    logic                         full;
    logic                         dump_last;

    assign busy   = (state_reg == S_DUMP);
    assign accept = start && !busy;

    // position range checks against the current count
    assign cnt7    = plsu_pkg::POS_W'(count_reg);
    assign pos_x   = {1'b0, request.position};
    assign cnt_x   = {1'b0, cnt7};
    assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + (plsu_pkg::POS_W+1)'(1));
    assign del_bad = (pos_x == '0) || (pos_x > cnt_x);
    assign full    = (count_reg >= CW'(CAPACITY));
    assign dump_last = (CW'(k_reg) == count_reg - CW'(1));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctl.cmd     = plsu_pkg::CMD_HOLD;
        ctl.idx     = request.position - plsu_pkg::POS_W'(1);
        ctl.cnt     = cnt7;

        if (state_reg == S_DUMP)
        begin
            ctl.cmd             = plsu_pkg::CMD_ROT;
            done_next           = 1'b1;
            result_next.status  = plsu_pkg::STAT_OK;
            result_next.element = q[0];
            result_next.length  = cnt7;
            result_next.last    = dump_last;
            k_next              = k_reg + KW'(1);
            if (dump_last)
                state_next = S_IDLE;
        end
        else if (accept)
        begin
            done_next           = 1'b1;
            result_next.status  = plsu_pkg::STAT_OK;
            result_next.element = '0;
            result_next.length  = cnt7;
            result_next.last    = 1'b1;
            case (request.func)
                plsu_pkg::FN_INSERT:
                begin
                    if (ins_bad)
                        result_next.status = plsu_pkg::STAT_BADPOS;
                    else if (full)
                        result_next.status = plsu_pkg::STAT_FULL;
                    else
                    begin
                        ctl.cmd            = plsu_pkg::CMD_INS;
                        count_next         = count_reg + CW'(1);
                        result_next.length = cnt7 + plsu_pkg::POS_W'(1);
                    end
                end
                plsu_pkg::FN_DELETE:
                begin
                    if (del_bad)
                        result_next.status = plsu_pkg::STAT_BADPOS;
                    else
                    begin
                        ctl.cmd            = plsu_pkg::CMD_DEL;
                        count_next         = count_reg - CW'(1);
                        result_next.length = cnt7 - plsu_pkg::POS_W'(1);
                    end
                end
                plsu_pkg::FN_DUMP:
                begin
                    if (count_reg != '0)
                    begin
                        done_next  = 1'b0;
                        state_next = S_DUMP;
                        k_next     = '0;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [plsu_pkg::DATA_W-1:0] prev_w;
        logic signed [plsu_pkg::DATA_W-1:0] next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_l
            assign prev_w = q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign next_w = '0;
        end
        else
        begin : g_mid_r
            assign next_w = q[g+1];
        end

        plsu_cell #(
            .IDX (g)
        ) u_cell (
            .clk  (clk),
            .ctl  (ctl),
            .din  (request.value),
            .prev (prev_w),
            .next (next_w),
            .head (q[0]),
            .q    (q[g])
        );
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/plsu_cell.sv]
// one storage cell of the list chain
module plsu_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  plsu_pkg::cell_ctl_t                ctl,
    input  logic signed [plsu_pkg::DATA_W-1:0] din,
    input  logic signed [plsu_pkg::DATA_W-1:0] prev,
    input  logic signed [plsu_pkg::DATA_W-1:0] next,
    input  logic signed [plsu_pkg::DATA_W-1:0] head,
    output logic signed [plsu_pkg::DATA_W-1:0] q
);

    localparam logic [plsu_pkg::POS_W-1:0] MY = plsu_pkg::POS_W'(IDX);

    logic signed [plsu_pkg::DATA_W-1:0] val_reg;
    logic signed [plsu_pkg::DATA_W-1:0] val_next;

    // pick the new content of this cell
    always_comb
    begin
        val_next = val_reg;
        case (ctl.cmd)
            plsu_pkg::CMD_INS:
            begin
                if (MY > ctl.idx)
                    val_next = prev;
                else if (MY == ctl.idx)
                    val_next = din;
            end
            plsu_pkg::CMD_DEL:
            begin
                if (MY >= ctl.idx)
                    val_next = next;
            end
            plsu_pkg::CMD_ROT:
            begin
                // occupied cells rotate toward the head, the head wraps to the tail
                if (MY == ctl.cnt - plsu_pkg::POS_W'(1))
                    val_next = head;
                else if (MY < ctl.cnt)
                    val_next = next;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // cell storage
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

[rtl/plsu_check.sv]
// port-level checks for the positional list store, bound to the top level
module plsu_check (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input plsu_pkg::in_item_t  request,
    input logic                done,
    input plsu_pkg::out_item_t result
);

    // a single-result item answers in the next cycle
    a_single_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func != plsu_pkg::FN_DUMP) |=> done)
        else $error("single-result item not answered in the next cycle");

    // dump results come back to back until the last one
    a_dump_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=> done)
        else $error("gap inside a dump run");

    // a non-final result only shows while the dump still holds busy
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> busy)
        else $error("non-final result outside a dump");

    // error results are single, final and carry no element
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != plsu_pkg::STAT_OK) |->
            (result.last && result.element == '0))
        else $error("malformed error result");

endmodule

bind positional_list_store_unit plsu_check u_plsu_check (.*);

[test/positional_list_store_unit_tb.sv]
// testbench for the positional list store: edits and dumps checked against a local list model
module positional_list_store_unit_tb;
    import plsu_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int RANDOM_OPS = 230;
    localparam int CALM_TAIL  = 40;
    localparam int DRAIN_WAIT = 40;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  request = '0;
    logic      done;
    out_item_t result;

    // items waiting for the driver and results waiting for the block
    in_item_t  pending_ops[$];
    out_item_t expected_results[$];

    // list model state
    logic signed [DATA_W-1:0] list_cells [CAP];
    int list_len = 0;

    int   error_count = 0;
    int   ops_total   = 0;
    int   ops_sent    = 0;
    int   gap_left    = 0;
    int   gen_len     = 0;
    logic item_taken;

    positional_list_store_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // list model: apply one item and queue the results it causes
    function automatic void apply_list_op(in_item_t op);
        out_item_t res;
        int pos;
        int i;
        res = '0;
        res.last = 1'b1;
        res.status = STAT_OK;
        pos = op.position;
        case (op.func)
            FN_INSERT:
            begin
                if (pos < 1 || pos > list_len + 1)
                    res.status = STAT_BADPOS;
                else if (list_len >= CAP)
                    res.status = STAT_FULL;
                else
                begin
                    for (i = list_len; i >= pos; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[pos-1] = op.value;
                    list_len++;
                end
            end
            FN_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = STAT_BADPOS;
                else
                begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            FN_DUMP:
            begin
                if (list_len > 0)
                begin
                    for (i = 0; i < list_len; i++)
                    begin
                        res.element = list_cells[i];
                        res.length  = POS_W'(list_len);
                        res.last    = (i == list_len - 1);
                        expected_results.push_back(res);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        res.length = POS_W'(list_len);
        expected_results.push_back(res);
    endfunction

    // queue one item and track the list length it leaves behind
    function automatic void add_op(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v, int p);
        in_item_t op;
        op.func = f;
        op.value = v;
        op.position = POS_W'(p);
        pending_ops.push_back(op);
        if (f == FN_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < CAP)
            gen_len++;
        else if (f == FN_DELETE && p >= 1 && p <= gen_len)
            gen_len--;
    endfunction

    // random value with extra weight on the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        logic     next_start;
        in_item_t next_req;
        next_start = start;
        next_req = request;
        if (!rst_n)
            next_start = 1'b0;
        else if (!start || item_taken)
        begin
            next_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops.size() != 0)
            begin
                next_req = pending_ops.pop_front();
                next_start = 1'b1;
                ops_sent++;
                // random pause after this item, none near the end
                if (ops_sent < ops_total - CALM_TAIL && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 11);
            end
        end
        start <= next_start;
        request <= next_req;
    end

    // monitor: check results first, then record the item taken at this edge
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d element %0d length %0d last %0d",
                           result.status, result.element, result.length, result.last);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        error_count++;
                    end
                    if (result.element !== want.element)
                    begin
                        $error("element: expected %0d, got %0d", want.element, result.element);
                        error_count++;
                    end
                    if (result.length !== want.length)
                    begin
                        $error("length: expected %0d, got %0d", want.length, result.length);
                        error_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        error_count++;
                    end
                end
            end
            item_taken <= start && !busy;
            if (start && !busy)
                apply_list_op(request);
        end
    end

    // stimulus and end of run
    initial
    begin
        int  r;
        int  full_hits;
        logic filling;

        // directed: empty cases, both ends, middle, bad positions, unused code
        add_op(FN_DUMP, pick_value(), $urandom_range(0, 127));
        add_op(FN_UNUSED, pick_value(), 0);
        add_op(FN_DELETE, pick_value(), 1);
        add_op(FN_INSERT, pick_value(), 0);
        add_op(FN_INSERT, pick_value(), 2);
        add_op(FN_INSERT, 32'sh7fff_ffff, 1);
        add_op(FN_INSERT, 32'sh8000_0000, 1);
        add_op(FN_INSERT, -32'sd1, 3);
        add_op(FN_INSERT, '0, 2);
        add_op(FN_INSERT, pick_value(), 127);
        add_op(FN_DUMP, pick_value(), 0);
        add_op(FN_DELETE, pick_value(), 0);
        add_op(FN_DELETE, pick_value(), 5);
        add_op(FN_DELETE, pick_value(), 127);
        add_op(FN_DELETE, pick_value(), 4);
        add_op(FN_DELETE, pick_value(), 1);
        add_op(FN_DUMP, pick_value(), 127);
        add_op(FN_UNUSED, $urandom, 127);
        add_op(FN_DELETE, pick_value(), 1);
        add_op(FN_DELETE, pick_value(), 1);
        add_op(FN_DUMP, pick_value(), 0);
        add_op(FN_INSERT, $urandom, 1);

        // random: fill to full, drain to empty, with noise in between
        filling = 1'b1;
        full_hits = 0;
        for (int k = 0; k < RANDOM_OPS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
                add_op(FN_DUMP, pick_value(), $urandom_range(0, 127));
            else if (r < 9)
                add_op(FN_UNUSED, pick_value(), $urandom_range(0, 127));
            else if (r < 19)
                add_op($urandom_range(0, 1) ? FN_DELETE : FN_INSERT, pick_value(),
                       $urandom_range(0, 127));
            else
            begin
                if (!filling && gen_len == 0)
                    filling = 1'b1;
                if (filling)
                begin
                    if (gen_len == CAP)
                        full_hits++;
                    // one try on a full list uses a bad position
                    if (full_hits == 1)
                        add_op(FN_INSERT, pick_value(), $urandom_range(CAP + 2, 127));
                    else
                        add_op(FN_INSERT, pick_value(), $urandom_range(1, gen_len + 1));
                    if (full_hits >= 3)
                    begin
                        filling = 1'b0;
                        full_hits = 0;
                    end
                end
                else
                    add_op(FN_DELETE, pick_value(), $urandom_range(1, gen_len));
            end
        end
        ops_total = pending_ops.size();

        // keep reset low, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every item to be taken and every result to arrive
        while (pending_ops.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
